>>> src/mbrtu_pkg.sv
// Shared types and constants for the Modbus RTU slave frame engine.
// No dependencies.
package mbrtu_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  MAX_UNIT = 8'd247;
  localparam logic [7:0]  FN_READ  = 8'h03;
  localparam logic [7:0]  FN_WRITE = 8'h06;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [7:0]  EXC_FUNC = 8'h01;
  localparam logic [7:0]  EXC_ADDR = 8'h02;
  localparam logic [7:0]  EXC_VAL  = 8'h03;

  localparam logic CFG_UNIT = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef enum logic [3:0] {
    ST_RX, ST_CHECK, ST_SCAN, ST_WRITE, ST_HDR, ST_RD_ADDR, ST_RD_HI, ST_RD_LO,
    ST_CRC_LO, ST_CRC_HI
  } state_t;

  // response kinds
  typedef enum logic [2:0] {
    RSP_NONE, RSP_FAULT, RSP_READ, RSP_ECHO, RSP_WRITE_ONLY
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_byte;   // accepted input byte
    logic       frame_end;   // clear count and crc
    logic       load_addr;   // start address into walker
    logic       step_addr;   // walker advance
    logic       store_wr;
    logic       crc_clear_tx;
    logic       emit;        // load output register
    logic [2:0] emit_sel;    // which byte to send
    logic       emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    rsp_t       rsp;
    logic       walk_bad;    // current walker address outside window
    logic       walk_done;
  } sts_t;

  localparam logic [2:0] SEL_UNIT  = 3'd0;
  localparam logic [2:0] SEL_FN    = 3'd1;
  localparam logic [2:0] SEL_B2    = 3'd2;
  localparam logic [2:0] SEL_HDR   = 3'd3;
  localparam logic [2:0] SEL_RDHI  = 3'd4;
  localparam logic [2:0] SEL_RDLO  = 3'd5;
  localparam logic [2:0] SEL_CRCLO = 3'd6;
  localparam logic [2:0] SEL_CRCHI = 3'd7;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/mbrtu_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mbrtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/mbrtu_ctrl.sv
// Controller state machine of the frame engine.
// Depends on mbrtu_pkg.
module mbrtu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic                 out_free,
  input  logic                 out_full,
  input  logic                 clr_busy,
  input  mbrtu_pkg::sts_t      sts,
  output logic                 in_ok,
  output mbrtu_pkg::cmd_t      cmd
);
  mbrtu_pkg::state_t st_r, st_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= mbrtu_pkg::ST_RX;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cmd = '0;
    in_ok = 1'b0;
    unique case (st_r)
      mbrtu_pkg::ST_RX: begin
        // hold off requests until the last response byte has gone out
        in_ok = !clr_busy && !out_full;
        cmd.take_byte = in_fire;
        if (in_fire && in_last) st_nxt = mbrtu_pkg::ST_CHECK;
      end
      mbrtu_pkg::ST_CHECK: begin
        cmd.frame_end = 1'b1;
        cmd.load_addr = 1'b1;
        cmd.crc_clear_tx = 1'b1;
        idx_nxt = '0;
        unique case (sts.rsp)
          mbrtu_pkg::RSP_FAULT, mbrtu_pkg::RSP_ECHO: st_nxt = mbrtu_pkg::ST_HDR;
          mbrtu_pkg::RSP_READ: st_nxt = mbrtu_pkg::ST_SCAN;
          mbrtu_pkg::RSP_WRITE_ONLY: st_nxt = mbrtu_pkg::ST_WRITE;
          default: st_nxt = mbrtu_pkg::ST_RX;
        endcase
      end
      mbrtu_pkg::ST_SCAN: begin
        // walk the read range once to find an out-of-window register
        cmd.step_addr = 1'b1;
        if (sts.walk_bad) begin
          st_nxt = mbrtu_pkg::ST_HDR;
        end else if (sts.walk_done) begin
          cmd.load_addr = 1'b1;
          cmd.step_addr = 1'b0;
          st_nxt = mbrtu_pkg::ST_HDR;
        end
      end
      mbrtu_pkg::ST_WRITE: begin
        cmd.store_wr = 1'b1;
        st_nxt = mbrtu_pkg::ST_RX;
      end
      mbrtu_pkg::ST_HDR: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = (idx_r == 3'd0) ? mbrtu_pkg::SEL_UNIT :
                         (idx_r == 3'd1) ? mbrtu_pkg::SEL_FN :
                         (idx_r == 3'd2) ? mbrtu_pkg::SEL_B2 : mbrtu_pkg::SEL_HDR;
          idx_nxt = idx_r + 3'd1;
          if (sts.rsp == mbrtu_pkg::RSP_ECHO) begin
            if (idx_r == 3'd0) cmd.store_wr = 1'b1;
            if (idx_r == 3'd5) st_nxt = mbrtu_pkg::ST_CRC_LO;
          end else if (idx_r == 3'd2) begin
            st_nxt = (sts.rsp == mbrtu_pkg::RSP_READ && !sts.walk_bad) ?
                     mbrtu_pkg::ST_RD_ADDR : mbrtu_pkg::ST_CRC_LO;
          end
        end
      end
      mbrtu_pkg::ST_RD_ADDR: begin
        // store read of the walker address lands in the next cycle
        st_nxt = mbrtu_pkg::ST_RD_HI;
      end
      mbrtu_pkg::ST_RD_HI: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = mbrtu_pkg::SEL_RDHI;
          st_nxt = mbrtu_pkg::ST_RD_LO;
        end
      end
      mbrtu_pkg::ST_RD_LO: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = mbrtu_pkg::SEL_RDLO;
          cmd.step_addr = 1'b1;
          st_nxt = sts.walk_done ? mbrtu_pkg::ST_CRC_LO : mbrtu_pkg::ST_RD_ADDR;
        end
      end
      mbrtu_pkg::ST_CRC_LO: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = mbrtu_pkg::SEL_CRCLO;
          st_nxt = mbrtu_pkg::ST_CRC_HI;
        end
      end
      mbrtu_pkg::ST_CRC_HI: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = mbrtu_pkg::SEL_CRCHI;
          cmd.emit_last = 1'b1;
          st_nxt = mbrtu_pkg::ST_RX;
        end
      end
      default: st_nxt = mbrtu_pkg::ST_RX;
    endcase
  end
endmodule

>>> src/mbrtu_dp.sv
// Datapath: receive CRC, header capture, request decode, address walker,
// holding store and response byte register. Depends on mbrtu_pkg, mbrtu_ram.
module mbrtu_dp #(
  parameter int MAX_REGISTERS = 16,
  parameter int MAX_FRAME     = 64,
  parameter int STORE_DEPTH   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        own_unit_id,
  input  logic [15:0]       window_base,
  input  mbrtu_pkg::cmd_t   cmd,
  input  logic              out_take,
  output mbrtu_pkg::sts_t   sts,
  output logic              out_full,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              clr_busy
);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QW = $clog2(MAX_REGISTERS + 1);

  logic [15:0] rx_crc_r;
  logic [6:0]  cnt_r;
  logic [7:0]  hdr_r [6];
  logic [15:0] tx_crc_r;
  logic [16:0] walk_r;      // current register address
  logic [QW-1:0] left_r;    // registers still to go
  mbrtu_pkg::rsp_t rsp_r;
  logic [7:0]  code_r;
  logic [7:0]  ob_r;
  logic        ol_r, ov_r;
  logic [AW:0] clr_r;
  logic [15:0] rdata;

  logic [15:0] addr, val;
  logic [16:0] off;
  logic        in_win;
  logic        unit_ok, bc, len_ok, is_rw, len8;
  logic        qty_bad;
  logic [7:0]  eb;
  logic [2:0]  walk_idx;
  logic [2:0]  echo_cnt_r;
  mbrtu_pkg::rsp_t rsp_dec;
  logic        walk_bad, walk_done;

  assign addr = {hdr_r[2], hdr_r[3]};
  assign val  = {hdr_r[4], hdr_r[5]};
  assign off  = walk_r - {1'b0, window_base};
  assign in_win = (walk_r >= {1'b0, window_base}) && (off < 17'(STORE_DEPTH));

  always_comb begin
    mbrtu_pkg::rsp_t r;
    unit_ok = (own_unit_id != 8'd0) && (own_unit_id <= mbrtu_pkg::MAX_UNIT);
    len_ok  = (cnt_r >= 7'd4) && (cnt_r <= 7'(MAX_FRAME)) && (rx_crc_r == 16'd0);
    bc      = (hdr_r[0] == 8'd0);
    is_rw   = (hdr_r[1] == mbrtu_pkg::FN_READ) || (hdr_r[1] == mbrtu_pkg::FN_WRITE);
    len8    = (cnt_r == 7'd8);
    qty_bad = (val == 16'd0) || (val > 16'(MAX_REGISTERS)) ||
              ({1'b0, addr} + {1'b0, val} > 17'h10000);
    r = mbrtu_pkg::RSP_NONE;
    if (unit_ok && len_ok && (bc || hdr_r[0] == own_unit_id)) begin
      if (!is_rw) begin
        r = bc ? mbrtu_pkg::RSP_NONE : mbrtu_pkg::RSP_FAULT;
      end else if (!len8) begin
        r = bc ? mbrtu_pkg::RSP_NONE : mbrtu_pkg::RSP_FAULT;
      end else if (hdr_r[1] == mbrtu_pkg::FN_READ) begin
        r = bc ? mbrtu_pkg::RSP_NONE : (qty_bad ? mbrtu_pkg::RSP_FAULT : mbrtu_pkg::RSP_READ);
      end else begin
        // window check of the write address happens on the walker
        r = bc ? mbrtu_pkg::RSP_WRITE_ONLY : mbrtu_pkg::RSP_ECHO;
      end
    end
    rsp_dec = (rsp_r == mbrtu_pkg::RSP_NONE) ? r : rsp_r;
  end

  // decoded kind is held from CHECK onward
  logic [7:0] code_nxt;
  always_comb begin
    code_nxt = mbrtu_pkg::EXC_FUNC;
    if (is_rw && !len8) code_nxt = mbrtu_pkg::EXC_VAL;
    else if (hdr_r[1] == mbrtu_pkg::FN_READ) code_nxt = qty_bad ? mbrtu_pkg::EXC_VAL
                                                                : mbrtu_pkg::EXC_ADDR;
    else if (hdr_r[1] == mbrtu_pkg::FN_WRITE) code_nxt = mbrtu_pkg::EXC_ADDR;
  end

  assign walk_bad  = !in_win &&
                     (rsp_r == mbrtu_pkg::RSP_READ || rsp_r == mbrtu_pkg::RSP_FAULT);
  assign walk_done = (left_r <= QW'(1));
  assign sts = '{rsp: rsp_dec, walk_bad: walk_bad, walk_done: walk_done};

  // writes of function 6: out-of-window address turns echo into fault / no-op
  logic wr_ok;
  assign wr_ok = in_win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_crc_r <= mbrtu_pkg::CRC_INIT;
      cnt_r    <= '0;
      rsp_r    <= mbrtu_pkg::RSP_NONE;
      ov_r     <= 1'b0;
      clr_r    <= '0;
    end else begin
      if (clr_r != (AW+1)'(STORE_DEPTH)) clr_r <= clr_r + (AW+1)'(1);
      if (cmd.take_byte) begin
        rx_crc_r <= mbrtu_pkg::crc_add(rx_crc_r, in_byte);
        if (cnt_r != 7'd127) cnt_r <= cnt_r + 7'd1;
      end
      if (cmd.frame_end) begin
        rx_crc_r <= mbrtu_pkg::CRC_INIT;
        cnt_r    <= '0;
      end
      if (cmd.load_addr && cmd.frame_end) begin
        rsp_r <= rsp_dec;
      end else if (cmd.step_addr && walk_bad) begin
        rsp_r <= mbrtu_pkg::RSP_FAULT;
      end
      if (cmd.emit_last || (cmd.store_wr && rsp_r == mbrtu_pkg::RSP_WRITE_ONLY))
        rsp_r <= mbrtu_pkg::RSP_NONE;
      if (rsp_r == mbrtu_pkg::RSP_ECHO && !wr_ok && !cmd.frame_end)
        rsp_r <= mbrtu_pkg::RSP_FAULT;
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && cnt_r < 7'd6) hdr_r[cnt_r[2:0]] <= in_byte;
    if (cmd.frame_end) code_r <= code_nxt;
    if (cmd.load_addr) begin
      walk_r <= {1'b0, addr};
      left_r <= QW'(val > 16'(MAX_REGISTERS) ? 16'd0 : val);
    end else if (cmd.step_addr) begin
      walk_r <= walk_r + 17'd1;
      left_r <= left_r - QW'(1);
    end
    // the CRC bytes themselves are not folded in
    if (cmd.crc_clear_tx) tx_crc_r <= mbrtu_pkg::CRC_INIT;
    else if (cmd.emit && cmd.emit_sel != mbrtu_pkg::SEL_CRCLO &&
             cmd.emit_sel != mbrtu_pkg::SEL_CRCHI)
      tx_crc_r <= mbrtu_pkg::crc_add(tx_crc_r, eb);
    if (cmd.emit) begin
      ob_r <= eb;
      ol_r <= cmd.emit_last;
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      mbrtu_pkg::SEL_UNIT:  eb = (rsp_r == mbrtu_pkg::RSP_ECHO) ? hdr_r[0] : own_unit_id;
      mbrtu_pkg::SEL_FN:    eb = (rsp_r == mbrtu_pkg::RSP_FAULT) ?
                                 (hdr_r[1] | mbrtu_pkg::EXC_FLAG) : hdr_r[1];
      mbrtu_pkg::SEL_B2:    eb = (rsp_r == mbrtu_pkg::RSP_FAULT) ? code_r :
                                 (rsp_r == mbrtu_pkg::RSP_READ) ? {hdr_r[5][6:0], 1'b0} : hdr_r[2];
      mbrtu_pkg::SEL_HDR:   eb = hdr_r[3'(walk_idx)];
      mbrtu_pkg::SEL_RDHI:  eb = rdata[15:8];
      mbrtu_pkg::SEL_RDLO:  eb = rdata[7:0];
      mbrtu_pkg::SEL_CRCLO: eb = tx_crc_r[7:0];
      default:              eb = tx_crc_r[15:8];
    endcase
  end

  // echo index follows emitted count: header emission counts 0..5
  always_ff @(posedge clk) begin
    if (cmd.crc_clear_tx) echo_cnt_r <= '0;
    else if (cmd.emit) echo_cnt_r <= echo_cnt_r + 3'd1;
  end
  assign walk_idx = echo_cnt_r;

  logic        ram_we;
  logic [AW-1:0] ram_a;
  logic [15:0] ram_wd;
  assign clr_busy = (clr_r != (AW+1)'(STORE_DEPTH));
  always_comb begin
    if (clr_busy) begin
      ram_we = 1'b1;
      ram_a  = clr_r[AW-1:0];
      ram_wd = 16'd0;
    end else begin
      ram_we = cmd.store_wr && wr_ok &&
               (rsp_r == mbrtu_pkg::RSP_ECHO || rsp_r == mbrtu_pkg::RSP_WRITE_ONLY);
      ram_a  = off[AW-1:0];
      ram_wd = val;
    end
  end

  mbrtu_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(rdata)
  );

  assign out_full = ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;
endmodule

>>> src/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave (function 3 / function 6) frame engine, top level.
// Depends on mbrtu_pkg, mbrtu_ctrl, mbrtu_dp, mbrtu_ram.
//
// Usage: request bytes enter on in_* one transfer at a time, in_tlast on the
// final byte of a frame. Bytes are taken back to back while the engine is
// receiving. After the final byte the engine checks the frame, then for a
// read walks the requested range (one register per cycle) and streams the
// response on out_*, tlast on the last CRC byte. Each read register is a
// store read followed by its high and low bytes. No new request byte is
// taken until the response has gone out. The output register holds its
// transfer while out_tready is low and the engine waits. After reset the
// holding store is cleared by a pass over all its words, during which no
// request byte is taken; configuration writes are taken at any time.
module modbus_rtu_slave_frame_engine #(
  parameter int MAX_REGISTERS = 16,
  parameter int MAX_FRAME     = 64,
  parameter int STORE_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [7:0]  own_unit_r;
  logic [15:0] base_r;
  mbrtu_pkg::cmd_t cmd;
  mbrtu_pkg::sts_t sts;
  logic in_ok, clr_busy, out_full, in_fire, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_unit_r <= 8'd1;
      base_r     <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbrtu_pkg::CFG_UNIT: own_unit_r <= cfg_wdata[7:0];
        mbrtu_pkg::CFG_BASE: base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = in_ok;
  assign in_fire   = in_tvalid && in_ok;
  assign out_take  = out_tvalid && out_tready;
  assign out_tvalid = out_full;

  mbrtu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_tlast),
    .out_free(!out_full || out_tready), .out_full(out_full), .clr_busy(clr_busy),
    .sts(sts), .in_ok(in_ok), .cmd(cmd)
  );

  mbrtu_dp #(
    .MAX_REGISTERS(MAX_REGISTERS), .MAX_FRAME(MAX_FRAME), .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_byte(in_tdata), .own_unit_id(own_unit_r),
    .window_base(base_r), .cmd(cmd), .out_take(out_take), .sts(sts),
    .out_full(out_full), .out_byte(out_tdata), .out_last(out_tlast),
    .clr_busy(clr_busy)
  );

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during response");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("output changed");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready) else $error("input during clear");
endmodule
